// ----- src/kchr_pkg.sv -----
package kchr_pkg;

   // Chord geometry: the ports always carry four slots, CHORD_KEYS limits which count.
   localparam int PRESS_SLOTS = 4;
   localparam int CHORD_KEYS = 4;
   localparam int KEYS_USED = (CHORD_KEYS < PRESS_SLOTS) ? CHORD_KEYS : PRESS_SLOTS;

   // Field widths.
   localparam int MASK_W = 4;
   localparam int PRESS_W = 4;
   localparam int DELTA_W = 8;
   localparam int EVENT_W = 16;
   localparam int CFG_W = 16;
   localparam int TIME_W = 32;

   // Default cap on results for one tick.
   localparam int DEF_MAX_RESULTS = 64;

   // Register map of the configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_TICKS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_TICKS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_ENABLE_MASK = 2'd2;

   // Decoded tick handed to the sequencer.
   typedef struct packed {
      logic still;
      logic [PRESS_W-1:0] trig;
      logic [DELTA_W-1:0] delta;
   } tick_type;

   // Timing registers seen by the sequencer.
   typedef struct packed {
      logic [CFG_W-1:0] hold_ticks;
      logic [CFG_W-1:0] repeat_ticks;
   } cfg_type;

   // One result produced by the sequencer.
   typedef struct packed {
      logic valid;
      logic [EVENT_W-1:0] event_number;
      logic last;
   } emit_type;

endpackage

// ----- src/kchr_alu.sv -----
module kchr_alu (
   input logic [kchr_pkg::TIME_W-1:0] a_i,
   input logic [kchr_pkg::TIME_W-1:0] b_i,
   input logic sub_i,
   output logic [kchr_pkg::TIME_W-1:0] sum_o,
   output logic carry_o
);
   import kchr_pkg::*;

   logic [TIME_W:0] full_w;
   logic [TIME_W-1:0] b_w;

   // Shared adder: for a subtraction a set carry means no borrow (a >= b).
   assign b_w = sub_i ? ~b_i : b_i;
   assign full_w = {1'b0, a_i} + {1'b0, b_w} + {{TIME_W{1'b0}}, sub_i};
   assign sum_o = full_w[TIME_W-1:0];
   assign carry_o = full_w[TIME_W];

endmodule

// ----- src/kchr_ctrl.sv -----
module kchr_ctrl #(
   parameter int MAX_RESULTS_PER_TICK = kchr_pkg::DEF_MAX_RESULTS
) (
   input logic clock,
   input logic reset,
   input logic start_i,
   input kchr_pkg::tick_type tick_i,
   input kchr_pkg::cfg_type cfg_i,
   input logic out_free_i,
   output logic idle_o,
   output kchr_pkg::emit_type emit_o
);
   import kchr_pkg::*;

   localparam int CW = $clog2(MAX_RESULTS_PER_TICK + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RESULTS_PER_TICK);
   localparam logic [EVENT_W-1:0] MAX_EVENTS16 = EVENT_W'(MAX_RESULTS_PER_TICK);
   localparam logic [CW-1:0] CNT_ONE = CW'(1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_CMP,
      S_TSTOP,
      S_TSTART,
      S_PSTOP,
      S_PSTART,
      S_REL,
      S_ADD,
      S_SUBH,
      S_DIV,
      S_TOTAL,
      S_CNT,
      S_REP
   } state_type;

   state_type state_ff;
   logic holding_ff;
   logic [TIME_W-1:0] held_time_ff;
   logic [EVENT_W-1:0] start_count_ff;
   logic [DELTA_W-1:0] delta_ff;
   logic [19:0] acc_ff;
   logic [4:0] step_ff;
   logic [PRESS_W-1:0] pairs_ff;
   logic cond_ff;
   logic [TIME_W-1:0] quo_ff;
   logic [CFG_W-1:0] rem_ff;
   logic [EVENT_W-1:0] total_ff;
   logic [CW-1:0] cnt_ff;

   logic [TIME_W-1:0] alu_a;
   logic [TIME_W-1:0] alu_b;
   logic alu_sub;
   logic [TIME_W-1:0] alu_sum;
   logic alu_carry;

   kchr_alu u_alu (
      .a_i(alu_a),
      .b_i(alu_b),
      .sub_i(alu_sub),
      .sum_o(alu_sum),
      .carry_o(alu_carry)
   );

   // Operand selection for the shared adder, one use per state.
   always_comb begin
      alu_a = '0;
      alu_b = '0;
      alu_sub = 1'b0;
      case (state_ff)
         S_MUL: begin
            alu_a = {12'd0, acc_ff};
            alu_b = {16'd0, cfg_i.hold_ticks};
         end
         S_CMP: begin
            alu_a = {24'd0, delta_ff};
            alu_b = {12'd0, acc_ff};
            alu_sub = 1'b1;
         end
         S_ADD: begin
            alu_a = held_time_ff;
            alu_b = {24'd0, delta_ff};
         end
         S_SUBH: begin
            alu_a = held_time_ff;
            alu_b = {16'd0, cfg_i.hold_ticks};
            alu_sub = 1'b1;
         end
         S_DIV: begin
            alu_a = {15'd0, rem_ff, quo_ff[TIME_W-1]};
            alu_b = {16'd0, cfg_i.repeat_ticks};
            alu_sub = 1'b1;
         end
         S_TOTAL: begin
            alu_a = quo_ff;
            alu_b = 32'd1;
         end
         S_CNT: begin
            alu_a = {16'd0, total_ff};
            alu_b = {16'd0, start_count_ff};
            alu_sub = 1'b1;
         end
         S_REP: begin
            alu_a = {16'd0, start_count_ff};
            alu_b = 32'd1;
         end
         default: begin
            alu_sub = 1'b0;
         end
      endcase
   end

   // Result offered to the output register in the emitting states.
   always_comb begin
      emit_o = '0;
      case (state_ff)
         S_TSTOP: begin
            emit_o.valid = out_free_i;
            emit_o.last = ~cond_ff;
         end
         S_TSTART: begin
            emit_o.valid = out_free_i;
            emit_o.event_number = 16'd1;
            emit_o.last = (pairs_ff == '0);
         end
         S_PSTOP: begin
            emit_o.valid = out_free_i;
         end
         S_PSTART: begin
            emit_o.valid = out_free_i;
            emit_o.event_number = 16'd1;
            emit_o.last = (pairs_ff == '0);
         end
         S_REL: begin
            emit_o.valid = out_free_i && (start_count_ff != '0);
            emit_o.last = 1'b1;
         end
         S_REP: begin
            emit_o.valid = out_free_i;
            emit_o.event_number = alu_sum[EVENT_W-1:0];
            emit_o.last = (cnt_ff == CNT_ONE);
         end
         default: begin
            emit_o.valid = 1'b0;
         end
      endcase
   end

   assign idle_o = (state_ff == S_IDLE);

   // Sequencer and hold state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         holding_ff <= 1'b0;
         held_time_ff <= '0;
         start_count_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start_i) begin
                  delta_ff <= tick_i.delta;
                  acc_ff <= '0;
                  step_ff <= {1'b0, tick_i.trig};
                  pairs_ff <= tick_i.trig - 4'd1;
                  if (tick_i.trig != '0) begin
                     state_ff <= S_MUL;
                  end else if (!holding_ff) begin
                     state_ff <= S_IDLE;
                  end else if (!tick_i.still) begin
                     state_ff <= S_REL;
                  end else begin
                     state_ff <= S_ADD;
                  end
               end
            end
            // Hold time times trigger count by repeated addition.
            S_MUL: begin
               acc_ff <= alu_sum[19:0];
               step_ff <= step_ff - 5'd1;
               if (step_ff == 5'd1) begin
                  state_ff <= S_CMP;
               end
            end
            S_CMP: begin
               cond_ff <= alu_carry;
               holding_ff <= 1'b1;
               if (start_count_ff != '0) begin
                  state_ff <= S_TSTOP;
               end else if (alu_carry) begin
                  state_ff <= S_TSTART;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_TSTOP: begin
               if (out_free_i) begin
                  start_count_ff <= '0;
                  held_time_ff <= '0;
                  state_ff <= cond_ff ? S_TSTART : S_IDLE;
               end
            end
            S_TSTART: begin
               if (out_free_i) begin
                  start_count_ff <= 16'd1;
                  state_ff <= (pairs_ff == '0) ? S_IDLE : S_PSTOP;
               end
            end
            S_PSTOP: begin
               if (out_free_i) begin
                  start_count_ff <= '0;
                  held_time_ff <= '0;
                  pairs_ff <= pairs_ff - 4'd1;
                  state_ff <= S_PSTART;
               end
            end
            S_PSTART: begin
               if (out_free_i) begin
                  start_count_ff <= 16'd1;
                  state_ff <= (pairs_ff == '0) ? S_IDLE : S_PSTOP;
               end
            end
            // Release: a stop goes out only when a start was counted.
            S_REL: begin
               if (out_free_i || (start_count_ff == '0)) begin
                  holding_ff <= 1'b0;
                  held_time_ff <= '0;
                  start_count_ff <= '0;
                  state_ff <= S_IDLE;
               end
            end
            // Saturating advance of the hold timer.
            S_ADD: begin
               held_time_ff <= alu_carry ? '1 : alu_sum;
               state_ff <= S_SUBH;
            end
            S_SUBH: begin
               if (!alu_carry) begin
                  state_ff <= S_IDLE;
               end else begin
                  quo_ff <= alu_sum;
                  rem_ff <= '0;
                  step_ff <= 5'd31;
                  total_ff <= 16'd1;
                  state_ff <= (cfg_i.repeat_ticks == '0) ? S_CNT : S_DIV;
               end
            end
            // One restoring division step a cycle, quotient shifted in below.
            S_DIV: begin
               rem_ff <= alu_carry ? alu_sum[CFG_W-1:0] : alu_a[CFG_W-1:0];
               quo_ff <= {quo_ff[TIME_W-2:0], alu_carry};
               step_ff <= step_ff - 5'd1;
               if (step_ff == '0) begin
                  state_ff <= S_TOTAL;
               end
            end
            S_TOTAL: begin
               if (alu_carry || (alu_sum[TIME_W-1:EVENT_W] != '0)) begin
                  total_ff <= '1;
               end else begin
                  total_ff <= alu_sum[EVENT_W-1:0];
               end
               state_ff <= S_CNT;
            end
            // Starts still owed, capped for this tick.
            S_CNT: begin
               if (!alu_carry || (alu_sum[EVENT_W-1:0] == '0)) begin
                  state_ff <= S_IDLE;
               end else begin
                  cnt_ff <= (alu_sum[EVENT_W-1:0] > MAX_EVENTS16) ? CNT_MAX
                                                                  : alu_sum[CW-1:0];
                  state_ff <= S_REP;
               end
            end
            S_REP: begin
               if (out_free_i) begin
                  start_count_ff <= alu_sum[EVENT_W-1:0];
                  cnt_ff <= cnt_ff - CNT_ONE;
                  if (cnt_ff == CNT_ONE) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // A released chord carries no count and no time.
   a_release_clear: assert property (@(posedge clock) disable iff (reset)
      !holding_ff |-> (start_count_ff == '0) && (held_time_ff == '0))
      else $error("hold state left over without holding");

   // The divider remainder stays below the divisor.
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < cfg_i.repeat_ticks))
      else $error("division remainder out of range");

   // Repeat emission never runs with nothing left to send.
   a_rep_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REP) |-> (cnt_ff != '0))
      else $error("repeat count exhausted");

   // A beat is offered only when the output register can take it.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit_o.valid |-> out_free_i)
      else $error("result offered to a full output register");

endmodule

// ----- src/key_chord_hold_repeat.sv -----
// Chord hold-and-repeat event generator for one chord of up to four key slots. Each
// request beat is one tick: held keys, new presses per key and elapsed ticks. Results
// are stop events (event number 0) and numbered start events, the final one of a tick
// marked by rsp_last; a tick with nothing to report gives no beat. One tick is handled
// at a time and req_ready is low while it is worked on. The hold and repeat arithmetic
// goes through one shared 32-bit adder under a sequencer. A press tick forms hold time
// times T (T is the largest press count) by repeated addition, compares it with the
// elapsed ticks and emits its results; a release tick emits at most one stop; a held
// tick advances the hold timer and, once the hold time is reached, works out the starts
// owed, with 32 restoring division steps and an increment when repeat is enabled.
// Results leave at one per cycle when the response side keeps up. Configuration writes
// are always accepted and must only be made while the block is idle.
module key_chord_hold_repeat #(
   parameter int MAX_RESULTS_PER_TICK = kchr_pkg::DEF_MAX_RESULTS
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [kchr_pkg::MASK_W-1:0] req_held_mask,
   input logic [kchr_pkg::PRESS_W-1:0] req_presses_key0,
   input logic [kchr_pkg::PRESS_W-1:0] req_presses_key1,
   input logic [kchr_pkg::PRESS_W-1:0] req_presses_key2,
   input logic [kchr_pkg::PRESS_W-1:0] req_presses_key3,
   input logic [kchr_pkg::DELTA_W-1:0] req_delta_ticks,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [kchr_pkg::EVENT_W-1:0] rsp_event_number,
   output logic rsp_last,
   input logic csr_valid,
   output logic csr_ready,
   input logic [kchr_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [kchr_pkg::CFG_W-1:0] csr_data
);
   import kchr_pkg::*;

   logic [CFG_W-1:0] hold_ticks_ff;
   logic [CFG_W-1:0] repeat_ticks_ff;
   logic [MASK_W-1:0] key_enable_mask_ff;

   logic rsp_valid_ff;
   logic [EVENT_W-1:0] rsp_event_number_ff;
   logic rsp_last_ff;

   logic [PRESS_W-1:0] presses_w [PRESS_SLOTS];
   logic any_w;
   logic all_held_w;
   logic [PRESS_W-1:0] max_w;
   tick_type tick_w;
   cfg_type cfg_w;
   emit_type emit_w;
   logic idle_w;
   logic out_free_w;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff <= '0;
         repeat_ticks_ff <= '0;
         key_enable_mask_ff <= 4'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HOLD_TICKS: begin
               hold_ticks_ff <= csr_data;
            end
            CSR_REPEAT_TICKS: begin
               repeat_ticks_ff <= csr_data;
            end
            CSR_KEY_ENABLE_MASK: begin
               key_enable_mask_ff <= csr_data[MASK_W-1:0];
            end
            default: begin
               hold_ticks_ff <= hold_ticks_ff;
            end
         endcase
      end
   end

   // Chord decode: held when every enabled slot is down, trigger is the top press count.
   assign presses_w[0] = req_presses_key0;
   assign presses_w[1] = req_presses_key1;
   assign presses_w[2] = req_presses_key2;
   assign presses_w[3] = req_presses_key3;

   always_comb begin
      any_w = 1'b0;
      all_held_w = 1'b1;
      max_w = '0;
      for (int i = 0; i < KEYS_USED; i++) begin
         if (key_enable_mask_ff[i]) begin
            any_w = 1'b1;
            if (!req_held_mask[i]) begin
               all_held_w = 1'b0;
            end
            if (presses_w[i] > max_w) begin
               max_w = presses_w[i];
            end
         end
      end
   end

   assign tick_w.still = any_w && all_held_w;
   assign tick_w.trig = tick_w.still ? max_w : '0;
   assign tick_w.delta = req_delta_ticks;
   assign cfg_w.hold_ticks = hold_ticks_ff;
   assign cfg_w.repeat_ticks = repeat_ticks_ff;

   assign req_ready = idle_w;
   assign out_free_w = !rsp_valid_ff || rsp_ready;

   kchr_ctrl #(
      .MAX_RESULTS_PER_TICK(MAX_RESULTS_PER_TICK)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start_i(req_valid && req_ready),
      .tick_i(tick_w),
      .cfg_i(cfg_w),
      .out_free_i(out_free_w),
      .idle_o(idle_w),
      .emit_o(emit_w)
   );

   // Output register holding one result beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_w.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_w.valid) begin
         rsp_event_number_ff <= emit_w.event_number;
         rsp_last_ff <= emit_w.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_event_number = rsp_event_number_ff;
   assign rsp_last = rsp_last_ff;

endmodule

// ----- bench/kchr_checker.sv -----
// Watches the request, response and register channels of the chord block, keeps its own
// copy of the hold state and the registers, and compares every response beat against the
// oldest predicted event.
module kchr_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic [kchr_pkg::MASK_W-1:0] req_held_mask,
   input logic [kchr_pkg::PRESS_W-1:0] req_presses_key0,
   input logic [kchr_pkg::PRESS_W-1:0] req_presses_key1,
   input logic [kchr_pkg::PRESS_W-1:0] req_presses_key2,
   input logic [kchr_pkg::PRESS_W-1:0] req_presses_key3,
   input logic [kchr_pkg::DELTA_W-1:0] req_delta_ticks,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [kchr_pkg::EVENT_W-1:0] rsp_event_number,
   input logic rsp_last,
   input logic csr_valid,
   input logic csr_ready,
   input logic [kchr_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [kchr_pkg::CFG_W-1:0] csr_data,
   output int error_count,
   output int events_outstanding,
   output int events_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESULT_CAP = kchr_pkg::DEF_MAX_RESULTS;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [kchr_pkg::EVENT_W-1:0] number;
      logic last;
   } chord_event_type;

   // Shadow of the registers.
   logic [kchr_pkg::CFG_W-1:0] cfg_hold;
   logic [kchr_pkg::CFG_W-1:0] cfg_repeat;
   logic [kchr_pkg::MASK_W-1:0] cfg_mask;

   // Shadow of the hold state.
   logic hold_active;
   logic [kchr_pkg::TIME_W-1:0] hold_timer;
   logic [kchr_pkg::EVENT_W-1:0] start_total;

   // Events of the tick being worked out, and events still owed by the block.
   chord_event_type tick_events[$];
   chord_event_type pending_events[$];

   // Events beyond the per-tick cap are dropped.
   function automatic void emit_event(input logic [kchr_pkg::EVENT_W-1:0] num);
      chord_event_type ev;
      if (tick_events.size() < RESULT_CAP) begin
         ev.number = num;
         ev.last = 1'b0;
         tick_events = {tick_events, ev};
      end
   endfunction

   // The start count saturates rather than wrapping to a stop.
   function automatic void count_start();
      if (start_total != '1) start_total = start_total + 1'b1;
      emit_event(start_total);
   endfunction

   // Ending a hold reports a stop only when a start was counted.
   function automatic void end_hold();
      logic had_start;
      had_start = (start_total != '0);
      hold_timer = '0;
      start_total = '0;
      hold_active = 1'b0;
      if (had_start) emit_event('0);
   endfunction

   // Works out the events of one tick and queues them behind those still owed.
   task automatic chord_tick_events(input logic [kchr_pkg::MASK_W-1:0] held,
                                    input logic [4*kchr_pkg::PRESS_W-1:0] presses,
                                    input logic [kchr_pkg::DELTA_W-1:0] delta);
      logic chord_held;
      logic any_slot;
      logic [kchr_pkg::PRESS_W-1:0] trig;
      logic [kchr_pkg::PRESS_W-1:0] pc;
      logic [kchr_pkg::TIME_W:0] sum;
      logic [kchr_pkg::TIME_W-1:0] target;
      logic [kchr_pkg::TIME_W-1:0] quot;
      chord_event_type ev;
      tick_events.delete();
      chord_held = 1'b1;
      any_slot = 1'b0;
      trig = '0;

      // The chord is held when every enabled slot is held; an empty chord never is.
      for (int k = 0; k < kchr_pkg::KEYS_USED; k++) begin
         if (cfg_mask[k]) begin
            pc = presses[k*kchr_pkg::PRESS_W +: kchr_pkg::PRESS_W];
            any_slot = 1'b1;
            if (!held[k]) chord_held = 1'b0;
            if (pc > trig) trig = pc;
         end
      end
      if (!any_slot) chord_held = 1'b0;
      if (!chord_held) trig = '0;

      // Each trigger restarts the hold and starts at once if delta >= hold time times trig.
      for (int t = 0; t < trig; t++) begin
         if (start_total != '0) end_hold();
         hold_active = 1'b1;
         if (32'(delta) >= 32'(cfg_hold) * 32'(trig)) count_start();
      end

      // A kept hold advances the saturating timer and catches up on owed starts.
      if (hold_active) begin
         if (!chord_held) begin
            end_hold();
         end else if (trig == '0) begin
            sum = {1'b0, hold_timer} + 33'(delta);
            hold_timer = sum[kchr_pkg::TIME_W] ? '1 : sum[kchr_pkg::TIME_W-1:0];
            if (hold_timer >= 32'(cfg_hold)) begin
               target = 32'd1;
               if (cfg_repeat != '0) begin
                  quot = (hold_timer - 32'(cfg_hold)) / 32'(cfg_repeat);
                  target = (quot >= 32'hFFFE) ? 32'hFFFF : quot + 32'd1;
               end
               while (32'(start_total) < target && tick_events.size() < RESULT_CAP)
                  count_start();
            end
         end
      end

      // Mark the final event of the tick.
      if (tick_events.size() > 0) begin
         ev = tick_events.pop_back();
         ev.last = 1'b1;
         tick_events = {tick_events, ev};
      end
      pending_events = {pending_events, tick_events};
   endtask

   // Response beats are checked before a request beat of the same edge is predicted.
   always @(posedge clock) begin
      chord_event_type want;
      if (reset) begin
         cfg_hold = '0;
         cfg_repeat = '0;
         cfg_mask = 4'd1;
         hold_active = 1'b0;
         hold_timer = '0;
         start_total = '0;
         pending_events.delete();
         error_count = 0;
         events_checked = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            events_checked++;
            if (pending_events.size() == 0) begin
               if (error_count < REPORT_LIMIT)
                  $display("%0t: unexpected response beat, event %0d last %0b",
                           $time, rsp_event_number, rsp_last);
               error_count++;
            end else begin
               want = pending_events.pop_front();
               if (rsp_event_number !== want.number || rsp_last !== want.last) begin
                  if (error_count < REPORT_LIMIT)
                     $display("%0t: mismatch, expected event %0d last %0b, %s %0d last %0b",
                              $time, want.number, want.last, "got event",
                              rsp_event_number, rsp_last);
                  error_count++;
               end
            end
         end
         // A request beat sees the registers as they stood before this edge.
         if (req_valid && req_ready)
            chord_tick_events(req_held_mask,
                              {req_presses_key3, req_presses_key2,
                               req_presses_key1, req_presses_key0},
                              req_delta_ticks);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               kchr_pkg::CSR_HOLD_TICKS: cfg_hold = csr_data;
               kchr_pkg::CSR_REPEAT_TICKS: cfg_repeat = csr_data;
               kchr_pkg::CSR_KEY_ENABLE_MASK: cfg_mask = csr_data[kchr_pkg::MASK_W-1:0];
               default: ;
            endcase
         end
      end
      events_outstanding <= pending_events.size();
   end

endmodule

// ----- bench/tb_top.sv -----
// Stimulus and verdict for the chord hold-and-repeat block; the checker beside it does the
// prediction and comparison.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import kchr_pkg::*;

   localparam int RESET_CYCLES = 7;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 150;
   localparam int RANDOM_TICKS = 300;
   localparam int PHASE_TICKS = 50;
   localparam int IDLE_PERCENT = 20;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [MASK_W-1:0] req_held_mask;
   logic [PRESS_W-1:0] req_presses_key0;
   logic [PRESS_W-1:0] req_presses_key1;
   logic [PRESS_W-1:0] req_presses_key2;
   logic [PRESS_W-1:0] req_presses_key3;
   logic [DELTA_W-1:0] req_delta_ticks;
   logic rsp_valid;
   logic rsp_ready;
   logic [EVENT_W-1:0] rsp_event_number;
   logic rsp_last;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_data;

   int error_count;
   int events_outstanding;
   int events_checked;

   // Stimulus control; quiet and rsp_hold_req are shared with the response side.
   logic quiet;
   logic rsp_hold_req;
   logic [MASK_W-1:0] chord_mask;
   int ticks_sent;
   int settings_used;

   key_chord_hold_repeat u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_held_mask(req_held_mask),
      .req_presses_key0(req_presses_key0),
      .req_presses_key1(req_presses_key1),
      .req_presses_key2(req_presses_key2),
      .req_presses_key3(req_presses_key3),
      .req_delta_ticks(req_delta_ticks),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_event_number(rsp_event_number),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   kchr_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_held_mask(req_held_mask),
      .req_presses_key0(req_presses_key0),
      .req_presses_key1(req_presses_key1),
      .req_presses_key2(req_presses_key2),
      .req_presses_key3(req_presses_key3),
      .req_delta_ticks(req_delta_ticks),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_event_number(rsp_event_number),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .error_count(error_count),
      .events_outstanding(events_outstanding),
      .events_checked(events_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Response side: random back-pressure, a quiet mode, and one long hold-off on request.
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req && !hold_done) begin
            rsp_ready <= 1'b0;
            hold_done = 1'b1;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else if (quiet) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // Elapsed time biased towards both extremes.
   function automatic logic [DELTA_W-1:0] pick_delta();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return DELTA_W'($urandom);
   endfunction

   // Offers one tick, after a random gap unless quiet, and returns once req_ready is high.
   task automatic send_tick(input logic [MASK_W-1:0] held,
                            input logic [4*PRESS_W-1:0] presses,
                            input logic [DELTA_W-1:0] delta);
      while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_held_mask <= held;
      req_presses_key0 <= presses[0*PRESS_W +: PRESS_W];
      req_presses_key1 <= presses[1*PRESS_W +: PRESS_W];
      req_presses_key2 <= presses[2*PRESS_W +: PRESS_W];
      req_presses_key3 <= presses[3*PRESS_W +: PRESS_W];
      req_delta_ticks <= delta;
      do @(posedge clock); while (!req_ready);
      ticks_sent++;
   endtask

   // Stops offering, waits for every owed event, then lets a no-result tick finish.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (events_outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers in one burst of beats; only called while idle.
   task automatic set_config(input logic [CFG_W-1:0] hold,
                             input logic [CFG_W-1:0] rpt,
                             input logic [MASK_W-1:0] mask);
      csr_valid <= 1'b1;
      csr_index <= CSR_HOLD_TICKS;
      csr_data <= hold;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_REPEAT_TICKS;
      csr_data <= rpt;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_KEY_ENABLE_MASK;
      csr_data <= {(CFG_W - MASK_W)'($urandom), mask};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      chord_mask = mask;
      settings_used++;
   endtask

   // A press, up to six held ticks and a release, with random content around the chord.
   task automatic chord_sequence();
      logic [4*PRESS_W-1:0] presses;
      logic [MASK_W-1:0] held;
      int hold_count;
      int slot;
      presses = 16'($urandom);
      if ($urandom_range(0, 9) < 7) presses &= 16'h3333;
      for (int k = 0; k < PRESS_SLOTS; k++) begin
         if (chord_mask[k]) begin
            if (presses[k*PRESS_W +: PRESS_W] == '0) presses[k*PRESS_W +: PRESS_W] = 4'd1;
            break;
         end
      end
      send_tick(chord_mask | MASK_W'($urandom), presses, pick_delta());

      hold_count = $urandom_range(0, 6);
      repeat (hold_count) begin
         presses = 16'($urandom);
         for (int k = 0; k < PRESS_SLOTS; k++)
            if (chord_mask[k]) presses[k*PRESS_W +: PRESS_W] = '0;
         send_tick(chord_mask | MASK_W'($urandom), presses, pick_delta());
      end

      // Release one enabled key of the chord.
      held = MASK_W'($urandom);
      if (chord_mask != '0) begin
         do slot = $urandom_range(0, PRESS_SLOTS - 1); while (!chord_mask[slot]);
         held[slot] = 1'b0;
      end
      send_tick(held, 16'($urandom), pick_delta());
   endtask

   initial begin
      int phase;
      int phase_end;
      int random_end;
      logic [MASK_W-1:0] mask;
      reset = 1'b1;
      req_valid = 1'b0;
      req_held_mask = '0;
      req_presses_key0 = '0;
      req_presses_key1 = '0;
      req_presses_key2 = '0;
      req_presses_key3 = '0;
      req_delta_ticks = '0;
      csr_valid = 1'b0;
      csr_index = CSR_HOLD_TICKS;
      csr_data = '0;
      quiet = 1'b0;
      rsp_hold_req = 1'b0;
      chord_mask = 4'd1;
      ticks_sent = 0;
      settings_used = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register defaults: immediate start, no repeat, slot 0 only.
      send_tick(4'h1, 16'h0001, 8'd0);
      send_tick(4'h1, 16'h0000, 8'd255);
      send_tick(4'h1, 16'h000F, 8'd255);
      send_tick(4'h0, 16'h0000, 8'd7);
      send_tick(4'h0, 16'hFFFF, 8'd7);
      send_tick(4'hF, 16'hFFFF, 8'd0);
      send_tick(4'hE, 16'h0000, 8'd0);
      drain();

      // Largest timings: presses never cover the hold, release without a start is silent.
      set_config(16'hFFFF, 16'hFFFF, 4'hF);
      send_tick(4'h7, 16'h5000, 8'd255);
      send_tick(4'hF, 16'hF030, 8'd255);
      send_tick(4'hF, 16'h0000, 8'd255);
      send_tick(4'h7, 16'h0000, 8'd255);
      drain();

      // Fast repeat on two slots: bursts past the cap are caught up on later ticks.
      set_config(16'd10, 16'd1, 4'hA);
      send_tick(4'hA, 16'h0020, 8'd20);
      send_tick(4'hF, 16'h0505, 8'd255);
      send_tick(4'hA, 16'h0000, 8'd0);
      send_tick(4'hA, 16'h0020, 8'd19);
      send_tick(4'hA, 16'h0000, 8'd0);
      send_tick(4'hA, 16'h0000, 8'd0);
      send_tick(4'h8, 16'h0000, 8'd3);
      drain();

      // Empty chord: nothing is ever held.
      set_config(16'd0, 16'd0, 4'h0);
      send_tick(4'hF, 16'hFFFF, 8'd255);
      send_tick(4'h0, 16'h1234, 8'd0);
      drain();

      // Random phases, mostly well-formed chords; the first one stalls the response side
      // and the third runs with no idling on either side.
      random_end = ticks_sent + RANDOM_TICKS;
      phase = 0;
      while (ticks_sent < random_end) begin
         mask = MASK_W'($urandom_range(1, 15));
         case (phase % 6)
            0: set_config(16'($urandom_range(0, 50)), 16'($urandom_range(1, 40)), mask);
            1: set_config(16'd0, 16'd1, mask);
            2: set_config(16'($urandom_range(0, 600)), 16'd0, mask);
            3: set_config(16'hFFFF, 16'($urandom), mask);
            4: set_config(16'($urandom_range(0, 200)), 16'hFFFF, mask);
            default: set_config(16'($urandom), 16'($urandom), MASK_W'($urandom));
         endcase
         if (phase == 0) rsp_hold_req <= 1'b1;
         quiet <= (phase == 2);
         phase_end = ticks_sent + PHASE_TICKS;
         while (ticks_sent < phase_end) begin
            if ($urandom_range(0, 9) < 8)
               chord_sequence();
            else
               send_tick(MASK_W'($urandom), 16'($urandom), DELTA_W'($urandom));
         end
         drain();
         phase++;
      end

      $display("Covered %0d ticks under %0d register settings and compared %0d result beats,",
               ticks_sent, settings_used, events_checked);
      $display("including a %0d-cycle response hold-off, a phase with no idling and bursts.",
               RSP_HOLD_CYCLES);
      if (error_count == 0 && events_outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #3_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
